>>> hw/rtl/sact_pkg.sv
// Shared constants, types and state codes for the set-associative cache tag model.
package sact_pkg;

    // Geometry of the memory and the cache tag model.
    localparam int MEM_WORDS  = 65536;
    localparam int LINE_WORDS = 16;
    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 4;
    localparam int AGE_BITS   = 16;

    // Field widths of the transactions.
    localparam int ADDR_BITS = 16;
    localparam int DATA_BITS = 32;
    localparam int CNT_BITS  = 32;

    // Derived widths.
    localparam int WIDX_BITS    = $clog2(MEM_WORDS);
    localparam int LINE_BITS    = $clog2(LINE_WORDS);
    localparam int SET_BITS     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_SHIFT    = $clog2(NUM_SETS);
    localparam int TAG_BITS     = ADDR_BITS - LINE_BITS - SET_SHIFT;
    localparam int WAY_IDX_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
    localparam logic [AGE_BITS-1:0] AGE_RESET = AGE_BITS'(1);

    // Access codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic                 command;
        logic [ADDR_BITS-1:0] address;
        logic [DATA_BITS-1:0] write_data;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 hit;
        logic [CNT_BITS-1:0]  hit_count;
        logic [CNT_BITS-1:0]  read_count;
    } t_out;

    // One way of a set.
    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [AGE_BITS-1:0] age;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
    } t_sts;

endpackage

>>> hw/rtl/set_assoc_cache_tag_model_unit.sv
// Top level of the set-associative cache tag model with its word memory.
// A result is valid once the execute step that follows its acceptance has ended.
// A new transaction is taken only in idle, not before the previous one is through its
// execute step, as the read-modify-write of one tag row spans capture and execute.
// Reset: counters and row valid bits clear at once; then a clearing pass zeroes all
// 65536 words of the word memory one word a cycle, during which no transaction is accepted.
module set_assoc_cache_tag_model_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sact_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sact_pkg::t_out o_out_data
);

    sact_pkg::t_cmd w_cmd;
    sact_pkg::t_sts w_sts;

    // Sequencing.
    sact_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Storage and compute.
    sact_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

>>> hw/rtl/sact_ctrl.sv
// Controller state machine: memory clearing pass, accept and execute sequencing.
module sact_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sact_pkg::t_cmd o_cmd,
    input  sact_pkg::t_sts i_sts
);

    sact_pkg::t_state r_state;
    sact_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;

    // A transaction is taken only in idle, and only when the result register frees up.
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sact_pkg::ST_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = sact_pkg::ST_IDLE;
                end
            end
            sact_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = sact_pkg::ST_EXEC;
                end
            end
            sact_pkg::ST_EXEC: begin
                n_state = sact_pkg::ST_IDLE;
            end
            default: begin
                n_state = sact_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.clear   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            sact_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            sact_pkg::ST_IDLE: begin
                o_in_ready    = !r_out_valid || i_out_ready;
                o_cmd.capture = i_in_valid && (!r_out_valid || i_out_ready);
            end
            sact_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Result valid: loaded when the execute step ends, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sact_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // An accepted transaction is executed in the very next cycle.
    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == sact_pkg::ST_EXEC)
        else $error("accepted transaction not executed next cycle");

    // The result register is free whenever a result is written into it.
    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sact_pkg::ST_EXEC |-> !r_out_valid)
        else $error("result register overwritten");

    // Every execute step leaves a result waiting.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sact_pkg::ST_EXEC |=> r_out_valid)
        else $error("execute step produced no result");

    // No transaction is taken during the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sact_pkg::ST_CLEAR |-> !o_in_ready && !o_cmd.capture)
        else $error("transaction accepted while clearing");

endmodule

>>> hw/rtl/sact_datapath.sv
// Datapath: word memory, tag row memory, aging and victim choice, counters, result register.
module sact_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sact_pkg::t_cmd i_cmd,
    output sact_pkg::t_sts o_sts,
    input  sact_pkg::t_in  i_in_data,
    output sact_pkg::t_out o_out_data
);

    // Memories.
    logic [sact_pkg::DATA_BITS-1:0] r_word_mem [sact_pkg::MEM_WORDS];
    sact_pkg::t_row                 r_tag_mem  [sact_pkg::NUM_SETS];

    // Per-row valid bits; a row not yet written reads as its reset contents.
    logic [sact_pkg::NUM_SETS-1:0]  r_row_vld;

    // Captured transaction.
    logic                           r_cmd_wr;
    logic [sact_pkg::SET_BITS-1:0]  r_set;
    logic [sact_pkg::TAG_BITS-1:0]  r_tag;
    logic [sact_pkg::WIDX_BITS-1:0] r_widx;
    logic [sact_pkg::DATA_BITS-1:0] r_wdata;

    // Registered memory reads.
    sact_pkg::t_row                 r_row_rd;
    logic                           r_row_vld_q;
    logic [sact_pkg::DATA_BITS-1:0] r_word_rd;

    // Clearing pass address, counters and result.
    logic [sact_pkg::WIDX_BITS-1:0] r_clr_addr;
    logic [sact_pkg::CNT_BITS-1:0]  r_hit_cnt;
    logic [sact_pkg::CNT_BITS-1:0]  r_rd_cnt;
    sact_pkg::t_out                 r_out;

    // Combinational values.
    logic [sact_pkg::ADDR_BITS-1:0]    w_line;
    logic [sact_pkg::SET_BITS-1:0]     w_set;
    logic [sact_pkg::TAG_BITS-1:0]     w_tag;
    sact_pkg::t_row                    w_row;
    sact_pkg::t_row                    n_row;
    logic [sact_pkg::AGE_BITS-1:0]     w_best;
    logic [sact_pkg::WAY_IDX_BITS-1:0] w_oldest;
    logic [sact_pkg::WAY_IDX_BITS-1:0] w_match;
    logic                              w_found;
    logic                              w_hit;
    logic [sact_pkg::CNT_BITS-1:0]     n_hit_cnt;
    logic [sact_pkg::CNT_BITS-1:0]     n_rd_cnt;
    logic                              w_mem_we;
    logic [sact_pkg::WIDX_BITS-1:0]    w_mem_waddr;
    logic [sact_pkg::DATA_BITS-1:0]    w_mem_wdata;

    // Address split into set and tag.
    assign w_line = i_in_data.address >> sact_pkg::LINE_BITS;
    assign w_set  = sact_pkg::SET_BITS'(w_line);
    assign w_tag  = sact_pkg::TAG_BITS'(w_line >> sact_pkg::SET_SHIFT);

    assign o_sts.clear_done = &r_clr_addr;
    assign o_out_data       = r_out;

    // Capture the transaction and read both memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_wr    <= i_in_data.command == sact_pkg::CMD_WRITE;
            r_set       <= w_set;
            r_tag       <= w_tag;
            r_widx      <= sact_pkg::WIDX_BITS'(i_in_data.address);
            r_wdata     <= i_in_data.write_data;
            r_row_rd    <= r_tag_mem[w_set];
            r_row_vld_q <= r_row_vld[w_set];
            r_word_rd   <= r_word_mem[sact_pkg::WIDX_BITS'(i_in_data.address)];
        end
    end

    // Age the set, refresh the highest matching way on a read hit or replace the oldest.
    always_comb begin
        w_best   = '0;
        w_oldest = '0;
        w_match  = '0;
        w_found  = 1'b0;
        for (int w = 0; w < sact_pkg::NUM_WAYS; w++) begin
            if (r_row_vld_q) begin
                w_row[w] = r_row_rd[w];
            end else begin
                w_row[w].valid = 1'b0;
                w_row[w].tag   = '0;
                w_row[w].age   = sact_pkg::AGE_RESET;
            end
            if (w_row[w].valid && (w_row[w].tag == r_tag)) begin
                w_match = sact_pkg::WAY_IDX_BITS'(w);
                w_found = 1'b1;
            end
            n_row[w] = w_row[w];
            if (w_row[w].age != sact_pkg::AGE_MAX) begin
                n_row[w].age = w_row[w].age + sact_pkg::AGE_BITS'(1);
            end
            if (n_row[w].age > w_best) begin
                w_best   = n_row[w].age;
                w_oldest = sact_pkg::WAY_IDX_BITS'(w);
            end
        end
        w_hit = !r_cmd_wr && w_found;
        if (w_hit) begin
            n_row[w_match].age = '0;
        end else begin
            n_row[w_oldest].valid = 1'b1;
            n_row[w_oldest].tag   = r_tag;
            n_row[w_oldest].age   = '0;
        end
    end

    // Counters including the current transaction.
    always_comb begin
        n_hit_cnt = r_hit_cnt + sact_pkg::CNT_BITS'(w_hit);
        n_rd_cnt  = r_rd_cnt + sact_pkg::CNT_BITS'(!r_cmd_wr);
    end

    // Tag row write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_tag_mem[r_set] <= n_row;
        end
    end

    // Word memory write port, shared by the clearing pass and stores.
    always_comb begin
        w_mem_we    = i_cmd.clear || (i_cmd.exec && r_cmd_wr);
        w_mem_waddr = i_cmd.clear ? r_clr_addr : r_widx;
        w_mem_wdata = i_cmd.clear ? '0 : r_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_word_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.read_data  <= r_cmd_wr ? '0 : r_word_rd;
            r_out.hit        <= w_hit;
            r_out.hit_count  <= n_hit_cnt;
            r_out.read_count <= n_rd_cnt;
        end
    end

    // Control state: row valid bits, clearing address and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_clr_addr <= '0;
            r_hit_cnt  <= '0;
            r_rd_cnt   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + sact_pkg::WIDX_BITS'(1);
            end
            if (i_cmd.exec) begin
                r_row_vld[r_set] <= 1'b1;
                r_hit_cnt        <= n_hit_cnt;
                r_rd_cnt         <= n_rd_cnt;
            end
        end
    end

    // A store never counts as a read.
    a_write_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_cmd_wr |=> $stable(r_rd_cnt) && $stable(r_hit_cnt))
        else $error("write transaction changed a counter");

    // A hit always counts a read as well.
    a_hit_counts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_hit |=> r_rd_cnt == $past(r_rd_cnt) + sact_pkg::CNT_BITS'(1))
        else $error("hit without read count");

    // The clearing address only moves during the clearing pass.
    a_clr_addr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clear |=> $stable(r_clr_addr))
        else $error("clearing address moved outside the clearing pass");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the set-associative cache tag model unit.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int SATURATE_ACCESSES = 16;

    // Keeps a copy of the tag rows, ages, counters and word memory, predicts the
    // result of each accepted access and checks the block's results in order.
    class cache_scoreboard;
        bit [sact_pkg::DATA_BITS-1:0] mem_words [sact_pkg::MEM_WORDS];
        bit [sact_pkg::TAG_BITS-1:0]  way_tag   [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
        bit                           way_used  [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
        bit [sact_pkg::AGE_BITS-1:0]  way_age   [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
        bit [sact_pkg::CNT_BITS-1:0]  hit_total;
        bit [sact_pkg::CNT_BITS-1:0]  read_total;
        sact_pkg::t_out               expected_results [$];
        int                           failures;

        function new();
            foreach (way_age[s, w]) begin
                way_age[s][w] = sact_pkg::AGE_RESET;
            end
            hit_total  = '0;
            read_total = '0;
            failures   = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Predict the result of one accepted access and update the model state.
        function void note_access(sact_pkg::t_in acc);
            int unsigned                 line_idx;
            int unsigned                 set_idx;
            int unsigned                 word_idx;
            bit [sact_pkg::TAG_BITS-1:0] tag_val;
            int                          match_way;
            int                          oldest_way;
            bit [sact_pkg::AGE_BITS-1:0] best_age;
            sact_pkg::t_out              res;

            line_idx  = acc.address / sact_pkg::LINE_WORDS;
            set_idx   = line_idx % sact_pkg::NUM_SETS;
            tag_val   = sact_pkg::TAG_BITS'(line_idx / sact_pkg::NUM_SETS);
            word_idx  = acc.address % sact_pkg::MEM_WORDS;
            res       = '0;
            match_way = -1;

            // Reads search the set first; the highest matching valid way wins.
            if (acc.command == sact_pkg::CMD_READ) begin
                read_total++;
                for (int w = 0; w < sact_pkg::NUM_WAYS; w++) begin
                    if (way_used[set_idx][w] && way_tag[set_idx][w] == tag_val) begin
                        match_way = w;
                    end
                end
            end

            // Age the whole set; the first way with the greatest age is the victim.
            best_age   = '0;
            oldest_way = 0;
            for (int w = 0; w < sact_pkg::NUM_WAYS; w++) begin
                if (way_age[set_idx][w] != sact_pkg::AGE_MAX) begin
                    way_age[set_idx][w]++;
                end
                if (way_age[set_idx][w] > best_age) begin
                    best_age   = way_age[set_idx][w];
                    oldest_way = w;
                end
            end

            // A hit refreshes the matching way; a miss or any write replaces the victim.
            if (match_way >= 0) begin
                hit_total++;
                res.hit = 1'b1;
                way_age[set_idx][match_way] = '0;
            end else begin
                way_tag[set_idx][oldest_way]  = tag_val;
                way_used[set_idx][oldest_way] = 1'b1;
                way_age[set_idx][oldest_way]  = '0;
            end

            if (acc.command == sact_pkg::CMD_READ) begin
                res.read_data = mem_words[word_idx];
            end else begin
                mem_words[word_idx] = acc.write_data;
            end
            res.hit_count  = hit_total;
            res.read_count = read_total;
            expected_results.push_back(res);
        endfunction

        function void check_field(string field_name, logic [sact_pkg::DATA_BITS-1:0] want,
                                  logic [sact_pkg::DATA_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field_name, want, got);
                failures++;
            end
        endfunction

        // Compare one result transaction with the oldest prediction.
        function void check_result(sact_pkg::t_out got);
            sact_pkg::t_out want;
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            check_field("read_data", want.read_data, got.read_data);
            check_field("hit", sact_pkg::DATA_BITS'(want.hit), sact_pkg::DATA_BITS'(got.hit));
            check_field("hit_count", want.hit_count, got.hit_count);
            check_field("read_count", want.read_count, got.read_count);
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    sact_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    sact_pkg::t_out o_out_data;

    cache_scoreboard board;
    bit              tx_idle_on    = 1'b0;
    bit              rx_idle_on    = 1'b0;
    bit              long_hold_req = 1'b0;
    int              focus_set     = 0;
    int unsigned     cycle_count   = 0;

    set_assoc_cache_tag_model_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every result transaction at the edge where it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_data);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES - 1;
                i_out_ready  <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left   = $urandom_range(1, 19) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [sact_pkg::ADDR_BITS-1:0] cache_address(int tag_v, int set_v,
                                                                     int offs);
        return sact_pkg::ADDR_BITS'(tag_v * sact_pkg::NUM_SETS * sact_pkg::LINE_WORDS
                                    + set_v * sact_pkg::LINE_WORDS + offs);
    endfunction

    function automatic sact_pkg::t_in access_of(logic cmd,
                                                logic [sact_pkg::ADDR_BITS-1:0] addr,
                                                logic [sact_pkg::DATA_BITS-1:0] data);
        sact_pkg::t_in acc;
        acc.command    = cmd;
        acc.address    = addr;
        acc.write_data = data;
        return acc;
    endfunction

    // Mostly accesses to a few neighboring sets with a handful of tags, so that
    // hits, evictions and read-back of written words are frequent.
    function automatic sact_pkg::t_in random_access();
        sact_pkg::t_in acc;
        acc.command    = ($urandom_range(0, 99) < 60) ? sact_pkg::CMD_READ
                                                      : sact_pkg::CMD_WRITE;
        acc.write_data = $urandom();
        if ($urandom_range(0, 9) < 7) begin
            acc.address = cache_address($urandom_range(0, 5),
                                        focus_set + $urandom_range(0, 2),
                                        $urandom_range(0, sact_pkg::LINE_WORDS - 1));
        end else begin
            acc.address = sact_pkg::ADDR_BITS'($urandom());
        end
        return acc;
    endfunction

    // Offer one input transaction, with an optional idle burst first, and wait
    // until it is accepted. Called and returns at a falling edge.
    task automatic send_access(sact_pkg::t_in acc);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= acc;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_access(acc);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random(int count, bit with_idling);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                focus_set  = $urandom_range(0, sact_pkg::NUM_SETS - 3);
                tx_idle_on = with_idling && ($urandom_range(0, 2) != 0);
                rx_idle_on = with_idling && ($urandom_range(0, 2) != 0);
            end
            send_access(random_access());
        end
    endtask

    // Main sequence.
    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty ways never match, even though their tag reads as zero.
        send_access(access_of(sact_pkg::CMD_READ, 16'h0000, 32'h0));
        send_access(access_of(sact_pkg::CMD_READ, 16'h0000, 32'h0));
        // Extremes of address and data.
        send_access(access_of(sact_pkg::CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF));
        send_access(access_of(sact_pkg::CMD_READ, 16'hFFFF, 32'h0));
        // A write places a tag already in the set; the read takes the higher way.
        send_access(access_of(sact_pkg::CMD_WRITE, cache_address(0, 0, 5), 32'hA5A5_A5A5));
        send_access(access_of(sact_pkg::CMD_READ, cache_address(0, 0, 5), 32'h0));
        // Fill one set from equal ages, then evict the oldest way.
        for (int t = 0; t < 5; t++) begin
            send_access(access_of(sact_pkg::CMD_READ, cache_address(t, 1, 3 * t), 32'h0));
        end
        send_access(access_of(sact_pkg::CMD_READ, cache_address(0, 1, 0), 32'h0));
        send_access(access_of(sact_pkg::CMD_READ, cache_address(3, 1, 1), 32'h0));
        send_access(access_of(sact_pkg::CMD_WRITE, 16'h8000, 32'h0000_0000));
        send_access(access_of(sact_pkg::CMD_READ, 16'h8000, 32'h0));
        send_access(access_of(sact_pkg::CMD_READ, 16'h7FFF, 32'h0));
        send_access(access_of(sact_pkg::CMD_WRITE, 16'h0001, 32'h0000_0001));
        send_access(access_of(sact_pkg::CMD_READ, 16'h0001, 32'h0));

        run_random(680, 1'b1);

        // Long receiver hold-off while the sender keeps offering, then a full drain.
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_access(random_access());
        end
        wait_drained();

        run_random(600, 1'b1);
        run_random(320, 1'b0);

        // Keep hitting one way so the other ways of the set grow old together,
        // then miss several times to evict the oldest ways in turn.
        for (int i = 0; i < SATURATE_ACCESSES; i++) begin
            send_access(access_of(sact_pkg::CMD_READ, cache_address(9, 42, 3), 32'h0));
        end
        for (int t = 10; t < 13; t++) begin
            send_access(access_of(sact_pkg::CMD_READ, cache_address(t, 42, t), 32'h0));
        end
        send_access(access_of(sact_pkg::CMD_READ, cache_address(9, 42, 3), 32'h0));

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sact_pkg.sv
hw/rtl/sact_ctrl.sv
hw/rtl/sact_datapath.sv
hw/rtl/set_assoc_cache_tag_model_unit.sv
tb/testbench.sv
